// ===== rtl/tls_sni_pkg.sv =====
// Package: shared types and constants for the TLS SNI host name extractor.
`default_nettype none

package tls_sni_pkg;

  // Bytes of record header ahead of the handshake message.
  localparam int unsigned RECORD_HEADER_BYTES = 5;
  // Handshake header, client version and random.
  localparam int unsigned FIXED_HELLO_BYTES   = 38;
  // Server name entry type for a host name.
  localparam logic [7:0]  SNI_TYPE_HOST       = 8'h00;

  // Width of the bounds arithmetic: offset + 4 + 16-bit length never overflows it.
  localparam int unsigned CALC_W = 19;
  typedef logic [CALC_W-1:0] calc_t;

  typedef enum logic [3:0] {
    PH_FIXED = 4'd0,
    PH_CS_HI = 4'd1,
    PH_CS_LO = 4'd2,
    PH_CM    = 4'd3,
    PH_EL_HI = 4'd4,
    PH_EL_LO = 4'd5,
    PH_ET0   = 4'd6,
    PH_ET1   = 4'd7,
    PH_XLH   = 4'd8,
    PH_XLL   = 4'd9,
    PH_SN_T  = 4'd10,
    PH_SN_LH = 4'd11,
    PH_SN_LL = 4'd12,
    PH_NAME  = 4'd13,
    PH_IDLE  = 4'd14
  } phase_e;

  typedef enum logic {
    KIND_NAME_BYTE = 1'b0,
    KIND_NO_NAME   = 1'b1
  } kind_e;

  typedef struct packed {
    logic [7:0]  data_byte;
    logic [15:0] packet_length;
    logic        end_of_packet;
  } in_item_t;

  typedef struct packed {
    kind_e      result_kind;
    logic [7:0] name_byte;
    logic       name_last;
  } result_t;

endpackage

`default_nettype wire

// ===== rtl/tls_sni_in_reg.sv =====
// Input register: holds one accepted payload byte until the parser takes it.
`default_nettype none

module tls_sni_in_reg (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  in_valid_i,
  output logic                       in_stall_o,
  input  wire logic [7:0]            data_byte_i,
  input  wire logic [15:0]           packet_length_i,
  input  wire logic                  end_of_packet_i,
  input  wire logic                  take_i,
  output logic                       valid_o,
  output tls_sni_pkg::in_item_t      item_o
);

  logic                  valid_q, valid_d;
  logic                  load;
  tls_sni_pkg::in_item_t item_q;

  // Full and not drained this cycle: hold off the sender.
  assign in_stall_o = valid_q && !take_i;
  assign load       = in_valid_i && !in_stall_o;

  always_comb begin
    valid_d = valid_q;
    if (load) begin
      valid_d = 1'b1;
    end else if (take_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      item_q.data_byte     <= data_byte_i;
      item_q.packet_length <= packet_length_i;
      item_q.end_of_packet <= end_of_packet_i;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

`default_nettype wire

// ===== rtl/tls_sni_parser.sv =====
// Parser: ClientHello walk state, bounds checks and per-byte result.
`default_nettype none

module tls_sni_parser (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  step_i,
  input  wire tls_sni_pkg::in_item_t item_i,
  output logic                       res_valid_o,
  output tls_sni_pkg::result_t       res_o
);

  localparam tls_sni_pkg::calc_t HdrEnd = tls_sni_pkg::calc_t'(
      tls_sni_pkg::RECORD_HEADER_BYTES + tls_sni_pkg::FIXED_HELLO_BYTES);

  tls_sni_pkg::phase_e phase_q, phase_d;
  logic [15:0] offset_q, offset_d;
  logic [16:0] sect_end_q, sect_end_d;
  logic [7:0]  len_hi_q, len_hi_d;
  logic [16:0] ext_end_q, ext_end_d;
  logic [16:0] entry_end_q, entry_end_d;
  logic        name_emitted_q, name_emitted_d;

  logic        emit;
  logic        last;

  tls_sni_pkg::calc_t off, plen, se;
  assign off  = tls_sni_pkg::calc_t'(offset_q);
  assign plen = tls_sni_pkg::calc_t'(item_i.packet_length);
  assign se   = tls_sni_pkg::calc_t'(sect_end_q);

  // Next state and datapath registers
  always_comb begin
    tls_sni_pkg::calc_t nx;
    tls_sni_pkg::calc_t len;
    tls_sni_pkg::calc_t start;
    logic [7:0]         b;

    b              = item_i.data_byte;
    nx             = '0;
    len            = '0;
    start          = '0;
    phase_d        = phase_q;
    offset_d       = offset_q;
    sect_end_d     = sect_end_q;
    len_hi_d       = len_hi_q;
    ext_end_d      = ext_end_q;
    entry_end_d    = entry_end_q;
    name_emitted_d = name_emitted_q;

    if (step_i) begin
      unique case (phase_q)
        tls_sni_pkg::PH_FIXED: begin
          if (off == HdrEnd) begin
            nx = HdrEnd + 1 + tls_sni_pkg::calc_t'(b);
            if ((HdrEnd + 1 > plen) || (nx + 2 > plen)) begin
              phase_d = tls_sni_pkg::PH_IDLE;
            end else begin
              sect_end_d = nx[16:0];
              phase_d    = tls_sni_pkg::PH_CS_HI;
            end
          end
        end
        tls_sni_pkg::PH_CS_HI: begin
          if (off == se) begin
            len_hi_d = b;
            phase_d  = tls_sni_pkg::PH_CS_LO;
          end
        end
        tls_sni_pkg::PH_CS_LO: begin
          nx = se + 2 + tls_sni_pkg::calc_t'({len_hi_q, b});
          if (nx + 1 > plen) begin
            phase_d = tls_sni_pkg::PH_IDLE;
          end else begin
            sect_end_d = nx[16:0];
            phase_d    = tls_sni_pkg::PH_CM;
          end
        end
        tls_sni_pkg::PH_CM: begin
          if (off == se) begin
            nx = se + 1 + tls_sni_pkg::calc_t'(b);
            if (nx + 2 > plen) begin
              phase_d = tls_sni_pkg::PH_IDLE;
            end else begin
              sect_end_d = nx[16:0];
              phase_d    = tls_sni_pkg::PH_EL_HI;
            end
          end
        end
        tls_sni_pkg::PH_EL_HI: begin
          if (off == se) begin
            len_hi_d = b;
            phase_d  = tls_sni_pkg::PH_EL_LO;
          end
        end
        tls_sni_pkg::PH_EL_LO: begin
          nx  = se + 2;
          len = tls_sni_pkg::calc_t'({len_hi_q, b});
          // list shorter than one extension header is rejected too
          if ((nx + len > plen) || (len < 4)) begin
            phase_d = tls_sni_pkg::PH_IDLE;
          end else begin
            ext_end_d  = 17'(nx + len);
            sect_end_d = nx[16:0];
            phase_d    = tls_sni_pkg::PH_ET0;
          end
        end
        tls_sni_pkg::PH_ET0: begin
          if (off == se) begin
            len_hi_d = b;
            phase_d  = tls_sni_pkg::PH_ET1;
          end
        end
        tls_sni_pkg::PH_ET1: begin
          // flag: extension type is server_name
          len_hi_d = {7'd0, (len_hi_q == 8'd0) && (b == 8'd0)};
          phase_d  = tls_sni_pkg::PH_XLH;
        end
        tls_sni_pkg::PH_XLH: begin
          entry_end_d = {9'd0, b};
          phase_d     = tls_sni_pkg::PH_XLL;
        end
        tls_sni_pkg::PH_XLL: begin
          len   = tls_sni_pkg::calc_t'({entry_end_q[7:0], b});
          start = se + 4;
          nx    = start + len;
          if (len_hi_q != 8'd0) begin
            if ((nx > tls_sni_pkg::calc_t'(ext_end_q)) || (start + 5 >= nx)) begin
              phase_d = tls_sni_pkg::PH_IDLE;
            end else begin
              entry_end_d = nx[16:0];
              sect_end_d  = 17'(start + 2);
              phase_d     = tls_sni_pkg::PH_SN_T;
            end
          end else begin
            if (nx + 4 > tls_sni_pkg::calc_t'(ext_end_q)) begin
              phase_d = tls_sni_pkg::PH_IDLE;
            end else begin
              sect_end_d = nx[16:0];
              phase_d    = tls_sni_pkg::PH_ET0;
            end
          end
        end
        tls_sni_pkg::PH_SN_T: begin
          if (off == se) begin
            len_hi_d = {7'd0, b == tls_sni_pkg::SNI_TYPE_HOST};
            phase_d  = tls_sni_pkg::PH_SN_LH;
          end
        end
        tls_sni_pkg::PH_SN_LH: begin
          ext_end_d = {9'd0, b};
          phase_d   = tls_sni_pkg::PH_SN_LL;
        end
        tls_sni_pkg::PH_SN_LL: begin
          len = tls_sni_pkg::calc_t'({ext_end_q[7:0], b});
          nx  = se + 3 + len;
          if (nx > tls_sni_pkg::calc_t'(entry_end_q)) begin
            phase_d = tls_sni_pkg::PH_IDLE;
          end else if (len_hi_q != 8'd0) begin
            if (len == '0) begin
              phase_d = tls_sni_pkg::PH_IDLE;
            end else begin
              sect_end_d = nx[16:0];
              phase_d    = tls_sni_pkg::PH_NAME;
            end
          end else begin
            if (nx + 3 >= tls_sni_pkg::calc_t'(entry_end_q)) begin
              phase_d = tls_sni_pkg::PH_IDLE;
            end else begin
              sect_end_d = nx[16:0];
              phase_d    = tls_sni_pkg::PH_SN_T;
            end
          end
        end
        tls_sni_pkg::PH_NAME: begin
          name_emitted_d = 1'b1;
          if (last) begin
            phase_d = tls_sni_pkg::PH_IDLE;
          end
        end
        default: begin
        end
      endcase

      if (item_i.end_of_packet) begin
        phase_d        = tls_sni_pkg::PH_FIXED;
        offset_d       = '0;
        sect_end_d     = '0;
        len_hi_d       = '0;
        ext_end_d      = '0;
        entry_end_d    = '0;
        name_emitted_d = 1'b0;
      end else if (offset_q != 16'hFFFF) begin
        offset_d = offset_q + 16'd1;
      end
    end
  end

  // Outputs
  always_comb begin
    emit = 1'b0;
    last = 1'b0;
    unique case (phase_q)
      tls_sni_pkg::PH_NAME: begin
        emit = 1'b1;
        last = (off + 1 >= se);
      end
      default: begin
      end
    endcase

    res_valid_o = step_i && (emit || (item_i.end_of_packet && !name_emitted_q));
    if (emit) begin
      res_o.result_kind = tls_sni_pkg::KIND_NAME_BYTE;
      res_o.name_byte   = item_i.data_byte;
      res_o.name_last   = last || item_i.end_of_packet;
    end else begin
      res_o.result_kind = tls_sni_pkg::KIND_NO_NAME;
      res_o.name_byte   = 8'd0;
      res_o.name_last   = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q        <= tls_sni_pkg::PH_FIXED;
      offset_q       <= '0;
      sect_end_q     <= '0;
      len_hi_q       <= '0;
      ext_end_q      <= '0;
      entry_end_q    <= '0;
      name_emitted_q <= 1'b0;
    end else begin
      phase_q        <= phase_d;
      offset_q       <= offset_d;
      sect_end_q     <= sect_end_d;
      len_hi_q       <= len_hi_d;
      ext_end_q      <= ext_end_d;
      entry_end_q    <= entry_end_d;
      name_emitted_q <= name_emitted_d;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/tls_sni_out_reg.sv =====
// Output register: holds one result item until the receiver takes it.
`default_nettype none

module tls_sni_out_reg (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 load_i,
  input  wire tls_sni_pkg::result_t res_i,
  output logic                      free_o,
  output logic                      out_valid_o,
  input  wire logic                 out_stall_i,
  output tls_sni_pkg::result_t      res_o
);

  logic                 valid_q, valid_d;
  tls_sni_pkg::result_t res_q;

  // Empty, or the held item leaves at this edge.
  assign free_o = !valid_q || !out_stall_i;

  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = 1'b1;
    end else if (!out_stall_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

  assign out_valid_o = valid_q;
  assign res_o       = res_q;

endmodule

`default_nettype wire

// ===== rtl/tls_sni_hostname_extractor_top.sv =====
// Top level: TLS ClientHello SNI host name extractor, one byte per cycle unless stalled.
`default_nettype none

// Channel   Direction  Handshake                 Payload
// ------    ---------  ------------------------  ------------------------------------------
// in        receive    in_valid_i / in_stall_o   data_byte_i, packet_length_i, end_of_packet_i
// out       send       out_valid_o / out_stall_i result_kind_o, name_byte_o, name_last_o
//
// One item in per cycle unless the receiver stalls. Each byte passes through the
// input register, then the parser logic feeding the output register.
// Each byte yields zero or one result item; the in and out registers are the only buffers.
// in_stall_o rises only when both the input register and the output register are
// full and the receiver stalls.
// Reset (rst_ni low, asynchronous) clears all valid flags and the parse state.

module tls_sni_hostname_extractor_top (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // payload bytes
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [7:0]  data_byte_i,
  input  wire logic [15:0] packet_length_i,
  input  wire logic        end_of_packet_i,
  // host name bytes / no-name marker
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic             result_kind_o,
  output logic [7:0]       name_byte_o,
  output logic             name_last_o
);

  logic                  item_valid;
  tls_sni_pkg::in_item_t item;
  logic                  out_free;
  logic                  step;
  logic                  res_valid;
  tls_sni_pkg::result_t  res;
  tls_sni_pkg::result_t  res_out;

  // The held byte is parsed whenever the output register can take its result.
  assign step = item_valid && out_free;

  tls_sni_in_reg u_in_reg (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .data_byte_i     (data_byte_i),
    .packet_length_i (packet_length_i),
    .end_of_packet_i (end_of_packet_i),
    .take_i          (step),
    .valid_o         (item_valid),
    .item_o          (item)
  );

  tls_sni_parser u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (step),
    .item_i      (item),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  tls_sni_out_reg u_out_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (res_valid),
    .res_i       (res),
    .free_o      (out_free),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .res_o       (res_out)
  );

  assign result_kind_o = res_out.result_kind;
  assign name_byte_o   = res_out.name_byte;
  assign name_last_o   = res_out.name_last;

endmodule

`default_nettype wire
